// File: design/hwbw_pkg.sv
// Shared types and constants for the hue-weighted black-and-white unit.
`default_nettype none

package hwbw_pkg;

  // Channel and weight widths
  localparam int unsigned PixW     = 8;
  localparam int unsigned WeightW  = 8;
  localparam int unsigned NumWeights = 6;
  localparam int unsigned CfgIdxW  = 3;

  // Percent scale and weight limits
  localparam int Percent   = 100;
  localparam int WeightMax = 100;
  localparam int WeightMin = -100;

  // Width of min*100 (255*100 < 2**15), of the signed sum and of the products
  localparam int unsigned BaseW = 15;
  localparam int unsigned ProdW = PixW + 1 + WeightW;
  localparam int unsigned AccW  = ProdW + 2;

  // Divide by 100 through a reciprocal: q = (acc * RecipMul) >> RecipShift,
  // exact for acc below 43690, and acc never exceeds 25500
  localparam int unsigned RecipShift = 21;
  localparam int unsigned RecipW     = 15;
  localparam logic [RecipW-1:0] RecipMul = RecipW'(((1 << RecipShift) + Percent - 1) / Percent);
  localparam int unsigned QProdW = BaseW + RecipW;

  // Hue slots, equal to the register indexes
  typedef enum logic [CfgIdxW-1:0] {
    HUE_RED     = 3'd0,
    HUE_YELLOW  = 3'd1,
    HUE_GREEN   = 3'd2,
    HUE_CYAN    = 3'd3,
    HUE_BLUE    = 3'd4,
    HUE_MAGENTA = 3'd5
  } hue_e;

  typedef logic signed [WeightW-1:0] weight_t;
  typedef logic [PixW-1:0] pix_t;

  // Weight values after reset, by hue slot
  localparam weight_t WeightReset [NumWeights] = '{
    weight_t'(40), weight_t'(60), weight_t'(40),
    weight_t'(60), weight_t'(20), weight_t'(80)
  };

endpackage

`default_nettype wire

// File: design/hue_weighted_black_white_unit.sv
// Top level of the hue-weighted black-and-white unit: a five-stage pixel pipeline.
//
// Usage:
//   A pixel request (pix_blue_i, pix_green_i, pix_red_i, pix_alpha_i) is taken at
//   each rising edge with start_i high and busy_o low. busy_o stays low, so one
//   pixel may enter in every cycle; pixels need not be contiguous.
//   The result (gray_level_o, alpha_out_o) is shown for one cycle with done_o
//   high, in request order. There is one register stage each for sort, weight
//   multiply, sum, reciprocal multiply for the divide by 100, and output.
//   Throughput is one pixel per clock, since every stage advances each cycle.
//   The receiver cannot stall the unit; every result appears exactly once.
//   Weights are written on the cfg channel (cfg_valid_i, cfg_index_i, cfg_data_i);
//   cfg_ready_o is always high, index 0..5 selects red, yellow, green, cyan, blue,
//   magenta, and other indexes are dropped. Values are clamped to -100..100 when
//   written. Write weights only while no pixel is in flight.
//   Reset (rst_ni low, asynchronous) empties the pipeline and loads the default
//   weights 40, 60, 40, 60, 20, 80.
`default_nettype none

module hue_weighted_black_white_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  hwbw_pkg::pix_t          pix_blue_i,
  input  hwbw_pkg::pix_t          pix_green_i,
  input  hwbw_pkg::pix_t          pix_red_i,
  input  hwbw_pkg::pix_t          pix_alpha_i,
  output logic                    done_o,
  output hwbw_pkg::pix_t          gray_level_o,
  output hwbw_pkg::pix_t          alpha_out_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [hwbw_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [hwbw_pkg::WeightW-1:0] cfg_data_i
);
  import hwbw_pkg::*;

  // Weight registers
  weight_t w_q [NumWeights];
  weight_t cfg_clamped;
  logic    cfg_we;

  // Stage 1: sorted channels
  logic s1_valid_q;
  pix_t s1_max_q, s1_mid_q, s1_min_q, s1_alpha_q;
  hue_e s1_pri_q, s1_sec_q;
  pix_t s1_max_d, s1_mid_d, s1_min_d;
  hue_e s1_pri_d, s1_sec_d;

  // Stage 2: products
  logic s2_valid_q;
  pix_t s2_alpha_q;
  logic signed [ProdW-1:0] s2_p1_q, s2_p2_q, s2_p1_d, s2_p2_d;
  logic [BaseW-1:0] s2_base_q, s2_base_d;
  weight_t w_pri, w_sec;

  // Stage 3: positive part of the sum
  logic s3_valid_q;
  pix_t s3_alpha_q;
  logic signed [AccW-1:0] acc_d;
  logic [BaseW-1:0] s3_acc_q, s3_acc_d;

  // Stage 4: reciprocal product
  logic s4_valid_q;
  pix_t s4_alpha_q;
  logic [QProdW-1:0] s4_qp_q, s4_qp_d;

  // Output stage
  logic done_q;
  pix_t gray_q, alpha_q;

  logic accept;

  assign accept      = start_i && !busy_o;
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Clamp the written weight to -100..100
  always_comb begin
    if ($signed(cfg_data_i) > $signed(WeightW'(WeightMax))) begin
      cfg_clamped = weight_t'(WeightMax);
    end else if ($signed(cfg_data_i) < $signed(WeightW'(WeightMin))) begin
      cfg_clamped = weight_t'(WeightMin);
    end else begin
      cfg_clamped = $signed(cfg_data_i);
    end
  end

  // Hold weights, load on a matching write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumWeights; i++) begin
        w_q[i] <= WeightReset[i];
      end
    end else begin
      for (int i = 0; i < NumWeights; i++) begin
        if (cfg_we && cfg_index_i == CfgIdxW'(i)) begin
          w_q[i] <= cfg_clamped;
        end
      end
    end
  end

  // Sort blue, green, red into max, mid, min; earlier channel wins ties
  always_comb begin
    pix_t v [3];
    hue_e h [3];
    pix_t tv;
    hue_e th;
    tv = '0;
    th = HUE_BLUE;
    v[0] = pix_blue_i;
    v[1] = pix_green_i;
    v[2] = pix_red_i;
    h[0] = HUE_BLUE;
    h[1] = HUE_GREEN;
    h[2] = HUE_RED;
    if (v[1] > v[0]) begin
      tv = v[0]; v[0] = v[1]; v[1] = tv;
      th = h[0]; h[0] = h[1]; h[1] = th;
    end
    if (v[2] > v[1]) begin
      tv = v[1]; v[1] = v[2]; v[2] = tv;
      th = h[1]; h[1] = h[2]; h[2] = th;
    end
    if (v[1] > v[0]) begin
      tv = v[0]; v[0] = v[1]; v[1] = tv;
      th = h[0]; h[0] = h[1]; h[1] = th;
    end
    s1_max_d = v[0];
    s1_mid_d = v[1];
    s1_min_d = v[2];
    s1_pri_d = h[0];
  end

  // Pick the secondary hue from the max and mid channels
  always_comb begin
    unique case (s1_pri_d)
      HUE_RED:   s1_sec_d = (s1_mid_hue() == HUE_GREEN) ? HUE_YELLOW : HUE_MAGENTA;
      HUE_GREEN: s1_sec_d = (s1_mid_hue() == HUE_RED) ? HUE_YELLOW : HUE_CYAN;
      default:   s1_sec_d = (s1_mid_hue() == HUE_RED) ? HUE_MAGENTA : HUE_CYAN;
    endcase
  end

  // Hue of the mid channel, recomputed from the compare results
  function automatic hue_e s1_mid_hue();
    hue_e h [3];
    hue_e th;
    h[0] = HUE_BLUE;
    h[1] = HUE_GREEN;
    h[2] = HUE_RED;
    if (pix_green_i > pix_blue_i) begin
      th = h[0]; h[0] = h[1]; h[1] = th;
    end
    if (pix_red_i > ((h[1] == HUE_GREEN) ? pix_green_i : pix_blue_i)) begin
      th = h[1]; h[1] = h[2]; h[2] = th;
    end
    if (h[1] == HUE_RED && pix_red_i > ((h[0] == HUE_GREEN) ? pix_green_i : pix_blue_i)) begin
      th = h[0]; h[0] = h[1]; h[1] = th;
    end
    return h[1];
  endfunction

  // Select weights by hue slot
  always_comb begin
    unique case (s1_pri_q)
      HUE_RED:     w_pri = w_q[HUE_RED];
      HUE_YELLOW:  w_pri = w_q[HUE_YELLOW];
      HUE_GREEN:   w_pri = w_q[HUE_GREEN];
      HUE_CYAN:    w_pri = w_q[HUE_CYAN];
      HUE_BLUE:    w_pri = w_q[HUE_BLUE];
      HUE_MAGENTA: w_pri = w_q[HUE_MAGENTA];
      default:     w_pri = '0;
    endcase
    unique case (s1_sec_q)
      HUE_RED:     w_sec = w_q[HUE_RED];
      HUE_YELLOW:  w_sec = w_q[HUE_YELLOW];
      HUE_GREEN:   w_sec = w_q[HUE_GREEN];
      HUE_CYAN:    w_sec = w_q[HUE_CYAN];
      HUE_BLUE:    w_sec = w_q[HUE_BLUE];
      HUE_MAGENTA: w_sec = w_q[HUE_MAGENTA];
      default:     w_sec = '0;
    endcase
  end

  // Weighted differences and the scaled minimum
  assign s2_p1_d   = $signed({1'b0, s1_max_q - s1_mid_q}) * w_pri;
  assign s2_p2_d   = $signed({1'b0, s1_mid_q - s1_min_q}) * w_sec;
  assign s2_base_d = BaseW'(s1_min_q * BaseW'(Percent));

  // Sum; a sum at or below zero gives gray zero
  assign acc_d    = AccW'(s2_p1_q) + AccW'(s2_p2_q) + $signed(AccW'(s2_base_q));
  assign s3_acc_d = (acc_d > 0) ? acc_d[BaseW-1:0] : '0;

  // Divide by 100 through the reciprocal
  assign s4_qp_d = QProdW'(s3_acc_q) * QProdW'(RecipMul);

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      done_q     <= s4_valid_q;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_max_q   <= s1_max_d;
      s1_mid_q   <= s1_mid_d;
      s1_min_q   <= s1_min_d;
      s1_pri_q   <= s1_pri_d;
      s1_sec_q   <= s1_sec_d;
      s1_alpha_q <= pix_alpha_i;
    end
    if (s1_valid_q) begin
      s2_p1_q    <= s2_p1_d;
      s2_p2_q    <= s2_p2_d;
      s2_base_q  <= s2_base_d;
      s2_alpha_q <= s1_alpha_q;
    end
    if (s2_valid_q) begin
      s3_acc_q   <= s3_acc_d;
      s3_alpha_q <= s2_alpha_q;
    end
    if (s3_valid_q) begin
      s4_qp_q    <= s4_qp_d;
      s4_alpha_q <= s3_alpha_q;
    end
    if (s4_valid_q) begin
      gray_q  <= s4_qp_q[RecipShift +: PixW];
      alpha_q <= s4_alpha_q;
    end
  end

  assign done_o       = done_q;
  assign gray_level_o = gray_q;
  assign alpha_out_o  = alpha_q;

endmodule

`default_nettype wire

// File: design/hwbw_checker.sv
// Port-level checks for the hue-weighted black-and-white unit, bound to the top level.
`default_nettype none

module hwbw_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start_i,
  input logic                    busy_o,
  input hwbw_pkg::pix_t          pix_blue_i,
  input hwbw_pkg::pix_t          pix_green_i,
  input hwbw_pkg::pix_t          pix_red_i,
  input hwbw_pkg::pix_t          pix_alpha_i,
  input logic                    done_o,
  input hwbw_pkg::pix_t          gray_level_o,
  input hwbw_pkg::pix_t          alpha_out_o
);
  import hwbw_pkg::*;

  // Every accepted request yields a result on done_o
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##5 done_o)
    else $error("accepted request produced no result");

  // No result without an earlier matching request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 5))
    else $error("result without a matching request");

  // The fourth channel passes through unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (alpha_out_o == $past(pix_alpha_i, 5)))
    else $error("alpha channel altered");

  // A gray input pixel keeps its level whatever the weights
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && pix_blue_i == pix_green_i && pix_green_i == pix_red_i)
      |-> ##5 (gray_level_o == $past(pix_red_i, 5)))
    else $error("gray pixel changed level");

endmodule

bind hue_weighted_black_white_unit hwbw_checker u_hwbw_checker (.*);

`default_nettype wire

// File: sim/hwbw_result_checker.sv
// Result checker for the hue-weighted black-and-white unit: predicts each gray level and compares.
module hwbw_result_checker
  import hwbw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_o,
  input  pix_t                 pix_blue_i,
  input  pix_t                 pix_green_i,
  input  pix_t                 pix_red_i,
  input  pix_t                 pix_alpha_i,
  input  logic                 done_o,
  input  pix_t                 gray_level_o,
  input  pix_t                 alpha_out_o,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [WeightW-1:0]   cfg_data_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          pending_count_o
);

  localparam int GrayMax  = 255;

  typedef struct {
    pix_t gray;
    pix_t alpha;
    pix_t blue;
    pix_t green;
    pix_t red;
  } gray_expect_t;

  // Weight values after reset, by hue slot
  localparam weight_t DefaultWeights [NumWeights] = '{
    weight_t'(40), weight_t'(60), weight_t'(40),
    weight_t'(60), weight_t'(20), weight_t'(80)
  };

  weight_t      weight_regs [NumWeights];
  gray_expect_t expected_gray_q [$];

  // Raw register values are kept; saturate to the percent range on use
  function automatic int percent_of(hue_e slot);
    int w;
    w = int'(weight_regs[slot]);
    if (w > WeightMax) w = WeightMax;
    if (w < WeightMin) w = WeightMin;
    return w;
  endfunction

  function automatic pix_t predict_gray(pix_t blue, pix_t green, pix_t red);
    int   chan [3];
    hue_e hue [3];
    hue_e second;
    hue_e hold_hue;
    int   lo;
    int   hold_val;
    int   stage;
    int   acc;
    int   quot;
    chan[0] = int'(blue);
    chan[1] = int'(green);
    chan[2] = int'(red);
    hue[0]  = HUE_BLUE;
    hue[1]  = HUE_GREEN;
    hue[2]  = HUE_RED;
    // Sort in three compare-exchange stages; swap only when the later one is strictly larger
    for (stage = 0; stage < 3; stage++) begin
      lo = (stage == 1) ? 1 : 0;
      if (chan[lo+1] > chan[lo]) begin
        hold_val    = chan[lo];
        chan[lo]    = chan[lo+1];
        chan[lo+1]  = hold_val;
        hold_hue    = hue[lo];
        hue[lo]     = hue[lo+1];
        hue[lo+1]   = hold_hue;
      end
    end
    // Pick the secondary; a red max with anything but green as mid goes to magenta
    case (hue[0])
      HUE_RED:   second = (hue[1] == HUE_GREEN) ? HUE_YELLOW : HUE_MAGENTA;
      HUE_GREEN: second = (hue[1] == HUE_RED) ? HUE_YELLOW : HUE_CYAN;
      default:   second = (hue[1] == HUE_RED) ? HUE_MAGENTA : HUE_CYAN;
    endcase
    acc = (chan[0] - chan[1]) * percent_of(hue[0])
        + (chan[1] - chan[2]) * percent_of(second)
        + chan[2] * Percent;
    quot = acc / Percent;
    if (quot < 0) quot = 0;
    if (quot > GrayMax) quot = GrayMax;
    return pix_t'(quot);
  endfunction

  // Compare results, track weight writes and queue predictions for accepted requests
  always @(posedge clk_i or negedge rst_ni) begin
    gray_expect_t want;
    gray_expect_t req;
    if (!rst_ni) begin
      foreach (weight_regs[i]) weight_regs[i] = DefaultWeights[i];
      expected_gray_q.delete();
      mismatch_count_o = 0;
    end else begin
      if (done_o) begin
        if (expected_gray_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got gray %0d alpha %0d",
                   $time, gray_level_o, alpha_out_o);
          mismatch_count_o++;
        end else begin
          want = expected_gray_q.pop_front();
          if (gray_level_o !== want.gray) begin
            $display("%0t: gray_level mismatch, expected %0d, got %0d (b %0d g %0d r %0d)",
                     $time, want.gray, gray_level_o, want.blue, want.green, want.red);
            mismatch_count_o++;
          end
          if (alpha_out_o !== want.alpha) begin
            $display("%0t: alpha_out mismatch, expected %0d, got %0d",
                     $time, want.alpha, alpha_out_o);
            mismatch_count_o++;
          end
        end
      end
      // Drop writes to indexes past the last weight
      if (cfg_valid_i && cfg_ready_o && (cfg_index_i < NumWeights))
        weight_regs[cfg_index_i] = weight_t'(cfg_data_i);
      if (start_i && !busy_o) begin
        req.blue  = pix_blue_i;
        req.green = pix_green_i;
        req.red   = pix_red_i;
        req.alpha = pix_alpha_i;
        req.gray  = predict_gray(pix_blue_i, pix_green_i, pix_red_i);
        expected_gray_q.push_back(req);
      end
    end
    pending_count_o = expected_gray_q.size();
  end

endmodule

// File: sim/tb_hue_weighted_black_white_unit.sv
// Testbench top for the hue-weighted black-and-white unit: stimulus, weight plans and verdict.
module tb_hue_weighted_black_white_unit;
  import hwbw_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int ItemsPerSet = 140;
  localparam int TailCycles  = 10;
  localparam int NumIndexes  = 1 << CfgIdxW;

  typedef enum int {
    PLAN_ALL_MAX,
    PLAN_ALL_MIN,
    PLAN_ABOVE_RANGE,
    PLAN_BELOW_RANGE,
    PLAN_ALL_ZERO,
    PLAN_ANY_BYTE,
    PLAN_IN_RANGE
  } weight_plan_e;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  pix_t                pix_blue_i;
  pix_t                pix_green_i;
  pix_t                pix_red_i;
  pix_t                pix_alpha_i;
  logic                done_o;
  pix_t                gray_level_o;
  pix_t                alpha_out_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [WeightW-1:0]  cfg_data_i;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned cycle_count;
  int unsigned idle_pct;
  weight_t     next_weights [NumWeights];

  hue_weighted_black_white_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .pix_blue_i   (pix_blue_i),
    .pix_green_i  (pix_green_i),
    .pix_red_i    (pix_red_i),
    .pix_alpha_i  (pix_alpha_i),
    .done_o       (done_o),
    .gray_level_o (gray_level_o),
    .alpha_out_o  (alpha_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  hwbw_result_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .pix_blue_i       (pix_blue_i),
    .pix_green_i      (pix_green_i),
    .pix_red_i        (pix_red_i),
    .pix_alpha_i      (pix_alpha_i),
    .done_o           (done_o),
    .gray_level_o     (gray_level_o),
    .alpha_out_o      (alpha_out_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_hue_weighted_black_white_unit: FAIL");
      $finish;
    end
  end

  // Favor the channel extremes
  function automatic pix_t skewed_channel();
    case ($urandom_range(0, 7))
      0:       return pix_t'(0);
      1:       return pix_t'(255);
      default: return pix_t'($urandom);
    endcase
  endfunction

  // Present one pixel request and hold it until taken
  task automatic send_pixel(input pix_t blue, input pix_t green, input pix_t red,
                            input pix_t alpha);
    start_i     <= 1'b1;
    pix_blue_i  <= blue;
    pix_green_i <= green;
    pix_red_i   <= red;
    pix_alpha_i <= alpha;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Idle for a random burst with junk on the pixel lines
  task automatic idle_burst();
    start_i     <= 1'b0;
    pix_blue_i  <= pix_t'($urandom);
    pix_green_i <= pix_t'($urandom);
    pix_red_i   <= pix_t'($urandom);
    pix_alpha_i <= pix_t'($urandom);
    repeat ($urandom_range(1, 13)) @(posedge clk_i);
  endtask

  // Hold off requests until every result is back
  task automatic drain_results();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0);
    @(posedge clk_i);
  endtask

  // Fill the weight set for a plan and write all indexes, the unused ones last
  task automatic load_weight_plan(input weight_plan_e plan);
    int idx;
    foreach (next_weights[i]) begin
      case (plan)
        PLAN_ALL_MAX:     next_weights[i] = weight_t'(WeightMax);
        PLAN_ALL_MIN:     next_weights[i] = weight_t'(WeightMin);
        PLAN_ABOVE_RANGE: next_weights[i] = weight_t'($urandom_range(WeightMax + 1, 127));
        PLAN_BELOW_RANGE: next_weights[i] = weight_t'($urandom_range(128, 155));
        PLAN_ALL_ZERO:    next_weights[i] = weight_t'(0);
        PLAN_ANY_BYTE:    next_weights[i] = weight_t'($urandom);
        default: begin
          if ($urandom_range(0, 7) == 0)
            next_weights[i] = weight_t'($urandom_range(0, 1) ? WeightMax : WeightMin);
          else
            next_weights[i] = weight_t'(int'($urandom_range(0, 200)) + WeightMin);
        end
      endcase
    end
    for (idx = 0; idx < NumIndexes; idx++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[CfgIdxW-1:0];
      cfg_data_i  <= (idx < NumWeights) ? next_weights[idx] : weight_t'($urandom);
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Random pixels with forced ties now and then; pause midway when asked
  task automatic random_pixels(input int count, input bit quiet, input bit pause_midway);
    int   n;
    pix_t blue;
    pix_t green;
    pix_t red;
    for (n = 0; n < count; n++) begin
      if (n % 32 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 50;
        endcase
        if (quiet) idle_pct = 0;
      end
      blue  = skewed_channel();
      green = skewed_channel();
      red   = skewed_channel();
      case ($urandom_range(0, 9))
        0: green = blue;
        1: red   = green;
        2: red   = blue;
        3: begin
          green = blue;
          red   = blue;
        end
        default: ;
      endcase
      send_pixel(blue, green, red, pix_t'($urandom));
      if ($urandom_range(0, 99) < idle_pct) idle_burst();
      if (pause_midway && (n == count / 2)) drain_results();
    end
    drain_results();
  endtask

  initial begin
    weight_plan_e plan_seq [$];
    int           p;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    pix_blue_i  = '0;
    pix_green_i = '0;
    pix_red_i   = '0;
    pix_alpha_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    idle_pct    = 0;
    plan_seq    = '{PLAN_ALL_MAX, PLAN_ALL_MIN, PLAN_ABOVE_RANGE, PLAN_BELOW_RANGE,
                    PLAN_ALL_ZERO, PLAN_ANY_BYTE, PLAN_IN_RANGE};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pixels on the default weights: extremes, every max/mid order, ties
    send_pixel(8'd0,   8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd10,  8'd100, 8'd200, 8'h55);
    send_pixel(8'd100, 8'd10,  8'd200, 8'hAA);  // red max, blue mid: magenta
    send_pixel(8'd10,  8'd200, 8'd100, 8'd1);
    send_pixel(8'd100, 8'd200, 8'd10,  8'd2);
    send_pixel(8'd200, 8'd10,  8'd100, 8'd3);
    send_pixel(8'd200, 8'd100, 8'd10,  8'd4);
    send_pixel(8'd0,   8'd0,   8'd255, 8'h80);
    send_pixel(8'd0,   8'd255, 8'd0,   8'h7F);
    send_pixel(8'd255, 8'd0,   8'd0,   8'hFF);
    send_pixel(8'd128, 8'd128, 8'd128, 8'h00);
    send_pixel(8'd200, 8'd200, 8'd50,  8'h0F);
    send_pixel(8'd50,  8'd200, 8'd200, 8'hF0);
    send_pixel(8'd200, 8'd50,  8'd200, 8'h33);
    send_pixel(8'd200, 8'd50,  8'd50,  8'hCC);
    send_pixel(8'd50,  8'd50,  8'd200, 8'h5A);
    send_pixel(8'd50,  8'd200, 8'd50,  8'hA5);
    drain_results();

    // Sweep the weight plans; the last one runs without idling
    for (p = 0; p < plan_seq.size(); p++) begin
      load_weight_plan(plan_seq[p]);
      random_pixels(ItemsPerSet, p == plan_seq.size() - 1, p == 1);
    end

    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("tb_hue_weighted_black_white_unit: PASS");
    else
      $display("tb_hue_weighted_black_white_unit: FAIL");
    $finish;
  end

endmodule
